### src/srb_pkg.sv
package srb_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_RADIUS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_VX    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_VY    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_VZ    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL   = 3'd7;

  // fixed datapath widths
  localparam int unsigned DW     = 33;  // position difference
  localparam int unsigned RB     = 33;  // square root bits
  localparam int unsigned SQ_W   = 66;  // sum of squares
  localparam int unsigned RAD_W  = 31;  // wall radius
  localparam int unsigned RND_W  = 16;  // random fraction
  localparam int unsigned SAT_W  = 96;  // wide work width before saturation

  localparam logic signed [SAT_W-1:0] S32_MAX = SAT_W'(64'sd2147483647);
  localparam logic signed [SAT_W-1:0] S32_MIN = -SAT_W'(64'sd2147483648);

  // magnitude of a 33 bit signed value
  function automatic logic [DW-1:0] mag33(input logic signed [DW-1:0] x);
    logic [DW-1:0] r;
    r = x[DW-1] ? DW'(-x) : DW'(x);
    return r;
  endfunction

  // saturate to signed 32 bits
  function automatic logic [31:0] sat32(input logic signed [SAT_W-1:0] x);
    logic [31:0] r;
    if (x > S32_MAX) r = S32_MAX[31:0];
    else if (x < S32_MIN) r = S32_MIN[31:0];
    else r = x[31:0];
    return r;
  endfunction

endpackage

### src/spherical_reflective_boundary_top.sv
// channel   direction  handshake          payload
// in        sink       in_valid/in_stall  in_pos_*, in_vel_*, step_level, random_fraction
// out       source     out_valid/out_stall out_pos_*, out_vel_*, was_outside, moving_inward,
//                                          far_beyond
// cfg       sink       cfg_we             cfg_index, cfg_data
//
// one item per cycle while out_stall is low; positions are Q16.16 at the default FRAC_BITS;
// the path runs through the 33 stage square root and the FRAC_BITS+1 stage divider
// rst is synchronous: clears valid bits and loads register defaults
// a stall holds the output; empty stages still fill, in_stall rises only when all are full
module spherical_reflective_boundary_top
  import srb_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [31:0]   in_pos_x,
  input  logic signed [31:0]   in_pos_y,
  input  logic signed [31:0]   in_pos_z,
  input  logic signed [31:0]   in_vel_x,
  input  logic signed [31:0]   in_vel_y,
  input  logic signed [31:0]   in_vel_z,
  input  logic [3:0]           step_level,
  input  logic [15:0]          random_fraction,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   out_pos_x,
  output logic signed [31:0]   out_pos_y,
  output logic signed [31:0]   out_pos_z,
  output logic signed [31:0]   out_vel_x,
  output logic signed [31:0]   out_vel_y,
  output logic signed [31:0]   out_vel_z,
  output logic                 was_outside,
  output logic                 moving_inward,
  output logic                 far_beyond,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int unsigned QB    = FRAC_BITS + 1;
  localparam int unsigned UW    = FRAC_BITS + 2;
  localparam int unsigned NW    = DW + FRAC_BITS;
  localparam int unsigned RMW   = RB + 3;
  localparam int unsigned DLW   = RB + 1;
  localparam int unsigned PW    = UW + DW;
  localparam int unsigned AW    = PW + 2;
  localparam int unsigned RVW   = AW - FRAC_BITS;
  localparam int unsigned MW    = DLW + 1;
  localparam int unsigned I_SQ0 = 3;
  localparam int unsigned I_RR  = I_SQ0 + RB - 1;
  localparam int unsigned I_DV0 = I_RR + 1;
  localparam int unsigned I_DVL = I_DV0 + QB - 1;
  localparam int unsigned I_U   = I_DVL + 1;
  localparam int unsigned I_M1  = I_U + 1;
  localparam int unsigned I_M2  = I_M1 + 1;
  localparam int unsigned I_M3  = I_M2 + 1;
  localparam int unsigned I_OUT = I_M3 + 1;
  localparam int unsigned NS    = I_OUT + 1;
  localparam int unsigned NC    = I_M3 + 1;

  // configuration registers
  logic [RAD_W-1:0]   wall_radius;
  logic signed [31:0] center [3];
  logic signed [31:0] frame_vel [3];
  logic [3:0]         min_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      wall_radius  <= RAD_W'(1) << FRAC_BITS;
      center[0]    <= '0;
      center[1]    <= '0;
      center[2]    <= '0;
      frame_vel[0] <= '0;
      frame_vel[1] <= '0;
      frame_vel[2] <= '0;
      min_level    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WALL_RADIUS: wall_radius  <= cfg_data[RAD_W-1:0];
        REG_CENTER_X:    center[0]    <= cfg_data;
        REG_CENTER_Y:    center[1]    <= cfg_data;
        REG_CENTER_Z:    center[2]    <= cfg_data;
        REG_FRAME_VX:    frame_vel[0] <= cfg_data;
        REG_FRAME_VY:    frame_vel[1] <= cfg_data;
        REG_FRAME_VZ:    frame_vel[2] <= cfg_data;
        REG_MIN_LEVEL:   min_level    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // valid bits and per stage load enables (bubbles fill under a stall)
  logic [NS-1:0] vld;
  logic [NS-1:0] rdy;

  always_comb begin
    rdy[NS-1] = !vld[NS-1] || !out_stall;
    for (int i = NS - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) vld[i] <= vld[i-1];
      end
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld[NS-1];

  // carried item data: offset from center, velocity in frame, fraction, skip
  logic signed [DW-1:0] cd [NC][3];
  logic signed [DW-1:0] cv [NC][3];
  logic [RND_W-1:0]     cf [NC];
  logic                 cs [NC];

  logic signed [31:0] in_pos [3];
  logic signed [31:0] in_vel [3];
  assign in_pos[0] = in_pos_x;
  assign in_pos[1] = in_pos_y;
  assign in_pos[2] = in_pos_z;
  assign in_vel[0] = in_vel_x;
  assign in_vel[1] = in_vel_y;
  assign in_vel[2] = in_vel_z;

  // stage 0: offsets and frame velocity
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int k = 0; k < 3; k++) begin
        cd[0][k] <= DW'(in_pos[k]) - DW'(center[k]);
        cv[0][k] <= DW'(in_vel[k]) - DW'(frame_vel[k]);
      end
      cf[0] <= random_fraction;
      cs[0] <= step_level < min_level;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 1; i < NC; i++) begin
      if (rdy[i]) begin
        cd[i] <= cd[i-1];
        cv[i] <= cv[i-1];
        cf[i] <= cf[i-1];
        cs[i] <= cs[i-1];
      end
    end
  end

  // stage 1: squares
  logic [SQ_W-1:0] sq [3];
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int k = 0; k < 3; k++) begin
        sq[k] <= SQ_W'(mag33(cd[0][k])) * SQ_W'(mag33(cd[0][k]));
      end
    end
  end

  // stage 2: sum of squares
  logic [SQ_W-1:0] sum_r;
  always_ff @(posedge clk) begin
    if (rdy[2]) sum_r <= sq[0] + sq[1] + sq[2];
  end

  // square root, one result bit per stage
  logic [RMW-1:0]  sq_rem  [RB];
  logic [RB-1:0]   sq_root [RB];
  logic [SQ_W-1:0] sq_rad  [RB];

  for (genvar s = 0; s < RB; s++) begin : g_sqrt
    logic [RMW-1:0]  rem_p;
    logic [RMW-1:0]  rem_sh;
    logic [RMW-1:0]  trial;
    logic [RB-1:0]   root_p;
    logic [SQ_W-1:0] rad_p;
    if (s == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = sum_r;
    end else begin : g_next
      assign rem_p  = sq_rem[s-1];
      assign root_p = sq_root[s-1];
      assign rad_p  = sq_rad[s-1];
    end
    assign rem_sh = {rem_p[RMW-3:0], rad_p[SQ_W-1:SQ_W-2]};
    assign trial  = {1'b0, root_p, 2'b01};
    always_ff @(posedge clk) begin
      if (rdy[I_SQ0+s]) begin
        if (rem_sh >= trial) begin
          sq_rem[s]  <= rem_sh - trial;
          sq_root[s] <= {root_p[RB-2:0], 1'b1};
        end else begin
          sq_rem[s]  <= rem_sh;
          sq_root[s] <= {root_p[RB-2:0], 1'b0};
        end
        sq_rad[s] <= {rad_p[SQ_W-3:0], 2'b00};
      end
    end
  end

  // unit vector magnitudes, one quotient bit per stage for all three lanes
  logic [NW-1:0] dv_r  [QB][3];
  logic [QB-1:0] dv_q  [QB][3];
  logic [RB-1:0] dv_rr [QB];

  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [RB-1:0] rr_p;
    logic [NW-1:0] rr_sh;
    if (j == 0) begin : g_first
      assign rr_p = sq_root[RB-1];
    end else begin : g_next
      assign rr_p = dv_rr[j-1];
    end
    assign rr_sh = NW'(rr_p) << (QB - 1 - j);
    always_ff @(posedge clk) begin
      if (rdy[I_DV0+j]) dv_rr[j] <= rr_p;
    end
    for (genvar k = 0; k < 3; k++) begin : g_lane
      logic [NW-1:0] r_p;
      logic [QB-1:0] q_p;
      if (j == 0) begin : g_first
        assign r_p = {mag33(cd[I_RR][k]), {FRAC_BITS{1'b0}}};
        assign q_p = '0;
      end else begin : g_next
        assign r_p = dv_r[j-1][k];
        assign q_p = dv_q[j-1][k];
      end
      always_ff @(posedge clk) begin
        if (rdy[I_DV0+j]) begin
          if (r_p >= rr_sh) begin
            dv_r[j][k] <= r_p - rr_sh;
            dv_q[j][k] <= {q_p[QB-2:0], 1'b1};
          end else begin
            dv_r[j][k] <= r_p;
            dv_q[j][k] <= {q_p[QB-2:0], 1'b0};
          end
        end
      end
    end
  end

  // signed unit vector, wall test, overshoot
  logic signed [UW-1:0]  u_r [3];
  logic signed [DLW-1:0] delr;
  logic                  outside_u;

  always_ff @(posedge clk) begin
    if (rdy[I_U]) begin
      for (int k = 0; k < 3; k++) begin
        if (dv_rr[QB-1] == '0) u_r[k] <= '0;
        else if (cd[I_DVL][k] < 0) u_r[k] <= -UW'(dv_q[QB-1][k]);
        else u_r[k] <= UW'(dv_q[QB-1][k]);
      end
      delr      <= $signed({1'b0, dv_rr[QB-1]}) - $signed(DLW'(wall_radius));
      outside_u <= !cs[I_DVL] && (dv_rr[QB-1] >= RB'(wall_radius));
    end
  end

  // m1: radial products, far test, random radius
  logic signed [PW-1:0]    prod [3];
  logic signed [UW-1:0]    u1 [3];
  logic signed [DLW-1:0]   delr1;
  logic [RAD_W-1:0]        newr;
  logic                    far1;
  logic                    outside1;
  logic signed [DLW+2:0]   five_delr;
  logic [RAD_W+RND_W-1:0]  rad_frac;

  assign five_delr = ((DLW+3)'(delr) <<< 2) + (DLW+3)'(delr);
  assign rad_frac  = (RAD_W+RND_W)'(wall_radius) * (RAD_W+RND_W)'(cf[I_U]);

  always_ff @(posedge clk) begin
    if (rdy[I_M1]) begin
      for (int k = 0; k < 3; k++) begin
        prod[k] <= u_r[k] * cv[I_U][k];
        u1[k]   <= u_r[k];
      end
      delr1    <= delr;
      far1     <= five_delr > $signed((DLW+3)'(wall_radius));
      newr     <= rad_frac[RAD_W+RND_W-1:RND_W];
      outside1 <= outside_u;
    end
  end

  // m2: radial velocity, position products
  logic signed [AW-1:0]    acc;
  logic signed [MW-1:0]    msel;
  logic signed [RVW-1:0]   rv;
  logic signed [MW+UW-1:0] pp [3];
  logic signed [UW-1:0]    u2 [3];
  logic                    far2;
  logic                    outside2;

  assign acc  = AW'(prod[0]) + AW'(prod[1]) + AW'(prod[2]);
  assign msel = far1 ? $signed(MW'(newr)) : (MW'(delr1) <<< 1);

  always_ff @(posedge clk) begin
    if (rdy[I_M2]) begin
      rv <= RVW'(acc >>> FRAC_BITS);
      for (int k = 0; k < 3; k++) begin
        pp[k] <= msel * u1[k];
        u2[k] <= u1[k];
      end
      far2     <= far1;
      outside2 <= outside1;
    end
  end

  // m3: velocity products, new position
  logic signed [RVW+UW-1:0] vp [3];
  logic signed [SAT_W-1:0]  psh [3];
  logic signed [SAT_W-1:0]  pos_w [3];
  logic [31:0]              pos3 [3];
  logic                     rvpos3;
  logic                     far3;
  logic                     outside3;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      psh[k] = SAT_W'(pp[k]) >>> FRAC_BITS;
      if (far2) pos_w[k] = psh[k] + SAT_W'(center[k]);
      else pos_w[k] = SAT_W'(cd[I_M2][k]) - psh[k] + SAT_W'(center[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[I_M3]) begin
      for (int k = 0; k < 3; k++) begin
        vp[k]   <= rv * u2[k];
        pos3[k] <= sat32(pos_w[k]);
      end
      rvpos3   <= rv > 0;
      far3     <= far2;
      outside3 <= outside2;
    end
  end

  // output register: reflected or passed values
  logic signed [SAT_W-1:0] vsh [3];
  logic signed [SAT_W-1:0] vel_w [3];
  logic signed [SAT_W-1:0] pin_w [3];
  logic signed [SAT_W-1:0] vin_w [3];
  logic [31:0]             pos_o [3];
  logic [31:0]             vel_o [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vsh[k]   = (SAT_W'(vp[k]) <<< 1) >>> FRAC_BITS;
      vel_w[k] = SAT_W'(cv[I_M3][k]) - vsh[k] + SAT_W'(frame_vel[k]);
      pin_w[k] = SAT_W'(cd[I_M3][k]) + SAT_W'(center[k]);
      vin_w[k] = SAT_W'(cv[I_M3][k]) + SAT_W'(frame_vel[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[I_OUT]) begin
      for (int k = 0; k < 3; k++) begin
        pos_o[k] <= outside3 ? pos3[k] : pin_w[k][31:0];
        vel_o[k] <= (outside3 && rvpos3) ? sat32(vel_w[k]) : vin_w[k][31:0];
      end
      was_outside   <= outside3;
      moving_inward <= outside3 && !rvpos3;
      far_beyond    <= outside3 && far3;
    end
  end

  assign out_pos_x = pos_o[0];
  assign out_pos_y = pos_o[1];
  assign out_pos_z = pos_o[2];
  assign out_vel_x = vel_o[0];
  assign out_vel_y = vel_o[1];
  assign out_vel_z = vel_o[2];

endmodule

### dv/tb_spherical_reflective_boundary_top.sv
`timescale 1ns / 1ps

module tb_spherical_reflective_boundary_top;
  import srb_pkg::*;

  localparam int FRAC = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT = 80;

  typedef struct {
    logic signed [31:0] px, py, pz, vx, vy, vz;
    logic [3:0]         level;
    logic [15:0]        frac;
    bit                 drain;
  } particle_t;

  typedef struct {
    logic signed [31:0] px, py, pz, vx, vy, vz;
    logic               outside, inward, far;
  } bounce_t;

  logic clk, rst;
  logic in_valid, in_stall;
  logic signed [31:0] in_pos_x, in_pos_y, in_pos_z, in_vel_x, in_vel_y, in_vel_z;
  logic [3:0] step_level;
  logic [15:0] random_fraction;
  logic out_valid, out_stall;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z, out_vel_x, out_vel_y, out_vel_z;
  logic was_outside, moving_inward, far_beyond;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  // testbench copy of the wall settings
  longint radius_m, min_level_m;
  longint ctr_m[3], fvel_m[3];

  particle_t particle_q[$];
  bounce_t   bounce_q[$];
  bit        in_taken;
  bit        idle_on;
  int        in_gap, stall_left;
  int        errors, cycles;

  spherical_reflective_boundary_top dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // floor square root of a sum of three squares
  function automatic longint root70(logic [69:0] s);
    logic [71:0] rem, root, trial;
    rem = 0;
    root = 0;
    for (int i = 34; i >= 0; i--) begin
      rem = (rem << 2) | 72'((s >> (2 * i)) & 70'd3);
      trial = (root << 2) | 72'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 72'd1;
      end else begin
        root = root << 1;
      end
    end
    return longint'(root);
  endfunction

  function automatic logic signed [31:0] clip32(longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // wall response for one particle
  function automatic bounce_t reflect_particle(particle_t it);
    longint p[3], v[3], d[3], u[3], vv[3], opos[3], ovel[3];
    longint rr, rv, acc, delr, newr;
    longint unsigned m;
    logic [69:0] ssum;
    bounce_t r;
    p[0] = it.px; p[1] = it.py; p[2] = it.pz;
    v[0] = it.vx; v[1] = it.vy; v[2] = it.vz;
    for (int k = 0; k < 3; k++) begin
      opos[k] = p[k];
      ovel[k] = v[k];
    end
    r.outside = 0;
    r.inward = 0;
    r.far = 0;
    if (longint'(it.level) >= min_level_m) begin
      ssum = 0;
      for (int k = 0; k < 3; k++) begin
        d[k] = p[k] - ctr_m[k];
        m = d[k] < 0 ? longint'(-d[k]) : longint'(d[k]);
        ssum = ssum + 70'(m) * 70'(m);
      end
      rr = root70(ssum);
      if (rr >= radius_m) begin
        r.outside = 1;
        acc = 0;
        for (int k = 0; k < 3; k++) begin
          u[k] = (rr != 0) ? (d[k] * (64'sd1 << FRAC)) / rr : 0;
          vv[k] = v[k] - fvel_m[k];
          acc += u[k] * vv[k];
        end
        rv = acc >>> FRAC;
        if (rv > 0) begin
          for (int k = 0; k < 3; k++)
            ovel[k] = vv[k] - ((2 * rv * u[k]) >>> FRAC) + fvel_m[k];
        end else begin
          r.inward = 1;
        end
        delr = rr - radius_m;
        if (5 * delr > radius_m) begin
          r.far = 1;
          newr = (radius_m * longint'(it.frac)) >>> 16;
          for (int k = 0; k < 3; k++)
            opos[k] = ((newr * u[k]) >>> FRAC) + ctr_m[k];
        end else begin
          for (int k = 0; k < 3; k++)
            opos[k] = d[k] - ((2 * delr * u[k]) >>> FRAC) + ctr_m[k];
        end
      end
    end
    r.px = clip32(opos[0]); r.py = clip32(opos[1]); r.pz = clip32(opos[2]);
    r.vx = clip32(ovel[0]); r.vy = clip32(ovel[1]); r.vz = clip32(ovel[2]);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // input driver
  always @(negedge clk) begin
    if (!rst && (in_taken || !in_valid)) begin
      in_taken <= 0;
      if (in_gap > 0) begin
        in_valid <= 0;
        in_gap <= in_gap - 1;
      end else if (particle_q.size() > 0 &&
                   !(particle_q[0].drain && bounce_q.size() > 0)) begin
        particle_t it;
        it = particle_q.pop_front();
        in_pos_x <= it.px; in_pos_y <= it.py; in_pos_z <= it.pz;
        in_vel_x <= it.vx; in_vel_y <= it.vy; in_vel_z <= it.vz;
        step_level <= it.level;
        random_fraction <= it.frac;
        in_valid <= 1;
        in_gap <= pick_gap();
      end else begin
        in_valid <= 0;
      end
    end
  end

  // output stall
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 0;
      stall_left <= pick_gap();
    end
  end

  // accepted items feed the prediction, accepted results are checked
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("spherical_reflective_boundary_top test failed");
      $finish;
    end else if (!rst) begin
      if (in_valid && !in_stall) begin
        particle_t it;
        it.px = in_pos_x; it.py = in_pos_y; it.pz = in_pos_z;
        it.vx = in_vel_x; it.vy = in_vel_y; it.vz = in_vel_z;
        it.level = step_level;
        it.frac = random_fraction;
        it.drain = 0;
        bounce_q.push_back(reflect_particle(it));
        in_taken <= 1;
      end
      if (out_valid && !out_stall) begin
        if (bounce_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result at cycle %0d", cycles);
        end else begin
          bounce_t e;
          e = bounce_q.pop_front();
          if (e.px !== out_pos_x || e.py !== out_pos_y || e.pz !== out_pos_z ||
              e.vx !== out_vel_x || e.vy !== out_vel_y || e.vz !== out_vel_z ||
              e.outside !== was_outside || e.inward !== moving_inward ||
              e.far !== far_beyond) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch at cycle %0d", cycles);
              $display("  exp pos %0d %0d %0d vel %0d %0d %0d flags %b%b%b",
                       e.px, e.py, e.pz, e.vx, e.vy, e.vz, e.outside, e.inward, e.far);
              $display("  got pos %0d %0d %0d vel %0d %0d %0d flags %b%b%b",
                       out_pos_x, out_pos_y, out_pos_z, out_vel_x, out_vel_y,
                       out_vel_z, was_outside, moving_inward, far_beyond);
            end
          end
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = data;
    case (idx)
      REG_WALL_RADIUS: radius_m = longint'(data[30:0]);
      REG_CENTER_X:    ctr_m[0] = longint'(signed'(data));
      REG_CENTER_Y:    ctr_m[1] = longint'(signed'(data));
      REG_CENTER_Z:    ctr_m[2] = longint'(signed'(data));
      REG_FRAME_VX:    fvel_m[0] = longint'(signed'(data));
      REG_FRAME_VY:    fvel_m[1] = longint'(signed'(data));
      REG_FRAME_VZ:    fvel_m[2] = longint'(signed'(data));
      REG_MIN_LEVEL:   min_level_m = longint'(data[3:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic set_wall(logic [30:0] rad, logic [31:0] cx, logic [31:0] cy,
                          logic [31:0] cz, logic [31:0] fx, logic [31:0] fy,
                          logic [31:0] fz, logic [3:0] lvl);
    write_reg(REG_WALL_RADIUS, {1'b0, rad});
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_FRAME_VX, fx);
    write_reg(REG_FRAME_VY, fy);
    write_reg(REG_FRAME_VZ, fz);
    write_reg(REG_MIN_LEVEL, {28'd0, lvl});
  endtask

  task automatic add_particle(longint px, longint py, longint pz, longint vx,
                              longint vy, longint vz, int lvl, int frac);
    particle_t it;
    it.px = px[31:0]; it.py = py[31:0]; it.pz = pz[31:0];
    it.vx = vx[31:0]; it.vy = vy[31:0]; it.vz = vz[31:0];
    it.level = lvl[3:0];
    it.frac = frac[15:0];
    it.drain = 0;
    particle_q.push_back(it);
  endtask

  // offset in [-m, m] from the centre
  function automatic longint offset(longint m);
    longint unsigned r;
    r = {$urandom, $urandom};
    return longint'(r % longint'(2 * m + 1)) - m;
  endfunction

  // particles spread around the wall, some fully random
  task automatic add_random(int n);
    longint m, vm;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        add_particle(signed'($urandom), signed'($urandom), signed'($urandom),
                     signed'($urandom), signed'($urandom), signed'($urandom),
                     $urandom_range(0, 15), $urandom_range(0, 65535));
      end else begin
        m = radius_m * $urandom_range(2, 12) / 8;
        if (m > 64'sd2147483647) m = 64'sd2147483647;
        if (m < 1) m = 1;
        vm = $urandom_range(0, 1) ? m : 64'sd2147483647;
        add_particle(ctr_m[0] + offset(m), ctr_m[1] + offset(m), ctr_m[2] + offset(m),
                     fvel_m[0] + offset(vm), fvel_m[1] + offset(vm),
                     fvel_m[2] + offset(vm), $urandom_range(0, 15),
                     $urandom_range(0, 65535));
      end
      // one hold-off until the pipeline has emptied
      if (i == n / 2) particle_q[$].drain = 1;
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (particle_q.size() > 0 || in_valid || bounce_q.size() > 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  initial begin
    rst = 1;
    in_valid = 0;
    out_stall = 0;
    in_pos_x = 0; in_pos_y = 0; in_pos_z = 0;
    in_vel_x = 0; in_vel_y = 0; in_vel_z = 0;
    step_level = 0;
    random_fraction = 0;
    cfg_we = 0;
    cfg_index = REG_WALL_RADIUS;
    cfg_data = 0;
    in_taken = 0;
    in_gap = 0;
    stall_left = 0;
    errors = 0;
    cycles = 0;
    idle_on = 1;
    radius_m = 65536;
    min_level_m = 0;
    for (int k = 0; k < 3; k++) begin
      ctr_m[k] = 0;
      fvel_m[k] = 0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: unit sphere at origin
    add_particle(0, 0, 0, 0, 0, 0, 0, 0);                       // at the centre
    add_particle(65536, 0, 0, 100, 0, 0, 15, 0);               // on the wall, outward
    add_particle(70000, 0, 0, -5, 3, 0, 7, 0);                 // inward
    add_particle(0, -70000, 0, 0, 0, 0, 1, 0);                 // zero radial velocity
    add_particle(0, 0, 200000, 5, 5, 9000, 2, 32768);          // far beyond
    add_particle(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                 -64'sd2147483648, -64'sd2147483648, -64'sd2147483648, 15, 65535);
    add_particle(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0);
    add_particle(-64'sd2147483648, 0, 0, -64'sd2147483648, 0, 0, 3, 65535);
    add_particle(40000, 40000, 40000, 32'sh7fffffff, 32'sh7fffffff, 0, 4, 1);
    add_particle(1000, -2000, 3000, 7, 8, 9, 5, 12345);         // inside
    add_particle(78643, 0, 0, 10, 0, 0, 6, 0);                  // just under 0.2 beyond
    add_particle(78644, 0, 0, 10, 0, 0, 6, 65535);              // just over 0.2 beyond
    add_random(60);
    wait_idle();

    // minimum radius, level filter at its top
    set_wall(31'd1, 0, 0, 0, 0, 0, 0, 4'd15);
    add_particle(5, 0, 0, 1, 0, 0, 14, 0);                      // below level
    add_particle(5, 0, 0, 1, 0, 0, 15, 0);
    add_particle(1, 0, 0, 1, 0, 0, 15, 100);
    add_particle(0, 0, 0, 1, 0, 0, 15, 0);
    add_random(60);
    wait_idle();

    // largest radius, extreme centre and frame velocity, no idling
    idle_on = 0;
    set_wall(31'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
             32'h80000000, 32'h7fffffff, 32'h80000000, 4'd0);
    add_random(70);
    wait_idle();

    // opposite extremes of the centre
    idle_on = 1;
    set_wall(31'h40000000, 32'h80000000, 32'h7fffffff, 32'h80000000,
             32'h7fffffff, 32'h80000000, 32'h7fffffff, 4'd8);
    add_random(60);
    wait_idle();

    // moderate random walls
    for (int ph = 0; ph < 3; ph++) begin
      set_wall(31'($urandom_range(1, 32'h00200000)), $urandom_range(0, 32'h000fffff) - 32'h80000,
               $urandom_range(0, 32'h000fffff) - 32'h80000,
               $urandom_range(0, 32'h000fffff) - 32'h80000, $urandom, $urandom,
               $urandom, 4'($urandom_range(0, 15)));
      add_random(50);
      wait_idle();
    end

    if (errors == 0) begin
      $display("spherical_reflective_boundary_top test passed");
    end else begin
      $display("spherical_reflective_boundary_top test failed");
    end
    $finish;
  end

endmodule
